// ----- rtl/core/bqc_pkg.sv -----
// package for the three-biquad tone cascade
// widths, register indexes, history row and coefficient types; no dependencies
package bqc_pkg;

   // sample and channel fields
   localparam int NUM_CHANNELS   = 2;
   localparam int CHAN_BITS      = 1;
   localparam int SAMPLE_BITS    = 24;

   // coefficients: Q3.14 signed
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC_BITS = 14;
   localparam int NUM_COEF_NUM   = 3;
   localparam int NUM_COEF_DEN   = 2;
   localparam int NUM_BITS       = NUM_COEF_NUM * COEF_BITS;
   localparam int DEN_BITS       = NUM_COEF_DEN * COEF_BITS;

   // cascade structure
   localparam int NUM_SECTIONS   = 3;
   localparam int SEC_BITS       = $clog2(NUM_SECTIONS);
   localparam int NUM_ROWS       = NUM_CHANNELS * NUM_SECTIONS;
   localparam int ROW_BITS       = $clog2(NUM_ROWS);

   // digit-serial multiply-accumulate
   localparam int DIGIT_BITS     = 4;
   localparam int NUM_DIGITS     = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int CNT_BITS       = $clog2(NUM_DIGITS + 1);

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = NUM_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTIVE         = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_SHELF_NUM  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_SHELF_DEN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_SHELF_NUM = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_SHELF_DEN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BELL_NUM       = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BELL_DEN       = 3'd6;

   // unity gain numerator: b0 = 1.0, b1 = b2 = 0
   localparam logic [NUM_BITS-1:0] NUM_RESET = NUM_BITS'(1) << COEF_FRAC_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;

   // coefficients of one section
   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   // history of one channel and section
   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_row_type;

   // history memory access
   typedef struct packed {
      logic                rd_en;
      logic [ROW_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [ROW_BITS-1:0] wr_addr;
      hist_row_type        wr_data;
   } hist_req_type;

   // multiply-accumulate control
   typedef struct packed {
      logic load;
      logic shift;
   } mac_ctrl_type;

endpackage

// ----- rtl/core/bqc_if.sv -----
// stream interfaces for sample requests and filtered responses
// depends on bqc_pkg for field widths
interface bqc_req_if;
   logic                            valid;
   logic                            ready;
   logic [bqc_pkg::CHAN_BITS-1:0]   channel;
   logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, channel, sample_in, input ready);
   modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface bqc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bqc_pkg::CHAN_BITS-1:0]   channel_out;
   logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, channel_out, sample_out, input ready);
   modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

// ----- rtl/core/bqc_csr.sv -----
// configuration registers: bypass flag and packed coefficients of the three sections
// depends on bqc_pkg; returns the coefficient set of the selected section
module bqc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bqc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bqc_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic [bqc_pkg::SEC_BITS-1:0]          sec,
   output logic                                  active,
   output bqc_pkg::coef_set_type                 coefs
);

   logic                          active_ff;
   logic [bqc_pkg::NUM_BITS-1:0]  num_ff [bqc_pkg::NUM_SECTIONS];
   logic [bqc_pkg::DEN_BITS-1:0]  den_ff [bqc_pkg::NUM_SECTIONS];
   logic [bqc_pkg::NUM_BITS-1:0]  num_sel;
   logic [bqc_pkg::DEN_BITS-1:0]  den_sel;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         for (int s = 0; s < bqc_pkg::NUM_SECTIONS; s++) begin
            num_ff[s] <= bqc_pkg::NUM_RESET;
            den_ff[s] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            bqc_pkg::REG_ACTIVE:         active_ff <= csr_data[0];
            bqc_pkg::REG_LOW_SHELF_NUM:  num_ff[0] <= csr_data[bqc_pkg::NUM_BITS-1:0];
            bqc_pkg::REG_LOW_SHELF_DEN:  den_ff[0] <= csr_data[bqc_pkg::DEN_BITS-1:0];
            bqc_pkg::REG_HIGH_SHELF_NUM: num_ff[1] <= csr_data[bqc_pkg::NUM_BITS-1:0];
            bqc_pkg::REG_HIGH_SHELF_DEN: den_ff[1] <= csr_data[bqc_pkg::DEN_BITS-1:0];
            bqc_pkg::REG_BELL_NUM:       num_ff[2] <= csr_data[bqc_pkg::NUM_BITS-1:0];
            bqc_pkg::REG_BELL_DEN:       den_ff[2] <= csr_data[bqc_pkg::DEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // section select and field unpacking, lowest field first
   always_comb begin
      num_sel = num_ff[0];
      den_sel = den_ff[0];
      for (int s = 1; s < bqc_pkg::NUM_SECTIONS; s++) begin
         if (sec == bqc_pkg::SEC_BITS'(s)) begin
            num_sel = num_ff[s];
            den_sel = den_ff[s];
         end
      end
      coefs.b0 = num_sel[0*bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
      coefs.b1 = num_sel[1*bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
      coefs.b2 = num_sel[2*bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
      coefs.a1 = den_sel[0*bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
      coefs.a2 = den_sel[1*bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
   end

   assign active = active_ff;

endmodule

// ----- rtl/core/bqc_hist_mem.sv -----
// history memory: one row of x1, x2, y1, y2 per channel and section
// depends on bqc_pkg; per-row valid bits make unwritten rows read as zero
module bqc_hist_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  bqc_pkg::hist_req_type req,
   output bqc_pkg::hist_row_type rd_data
);

   bqc_pkg::hist_row_type         mem [bqc_pkg::NUM_ROWS];
   logic [bqc_pkg::NUM_ROWS-1:0]  valid_ff;
   bqc_pkg::hist_row_type         rd_data_ff;
   logic                          rd_valid_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   // row valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req.wr_en) begin
            valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/bqc_mac.sv -----
// digit-serial multiply-accumulate for one biquad section, with rounding and saturation
// depends on bqc_pkg; five operands shift out one digit per cycle while shift is set, most significant first
module bqc_mac (
   input  logic                  clock,
   input  bqc_pkg::mac_ctrl_type ctrl,
   input  bqc_pkg::sample_type   x,
   input  bqc_pkg::hist_row_type row,
   input  bqc_pkg::coef_set_type coefs,
   output bqc_pkg::sample_type   y
);

   localparam int NUM_TERMS = 5;
   localparam int OPW       = bqc_pkg::NUM_DIGITS * bqc_pkg::DIGIT_BITS;
   localparam int MCOEF     = bqc_pkg::COEF_BITS + 1;
   localparam int PROD_BITS = MCOEF + bqc_pkg::DIGIT_BITS + 1;
   localparam int SUM_BITS  = PROD_BITS + 3;
   localparam int ACC_BITS  = MCOEF + bqc_pkg::SAMPLE_BITS + 3;
   localparam logic signed [ACC_BITS-1:0] HALF =
      ACC_BITS'(64'sd1 <<< (bqc_pkg::COEF_FRAC_BITS - 1));
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      ACC_BITS'((64'sd1 <<< (bqc_pkg::SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      ACC_BITS'(-(64'sd1 <<< (bqc_pkg::SAMPLE_BITS - 1)));

   logic signed [OPW-1:0]        opr_ff  [NUM_TERMS];
   logic signed [MCOEF-1:0]      coef_ff [NUM_TERMS];
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic                         first_ff;

   logic signed [bqc_pkg::DIGIT_BITS:0] dig  [NUM_TERMS];
   logic signed [PROD_BITS-1:0]         prod [NUM_TERMS];
   logic signed [SUM_BITS-1:0]          sum_in;
   logic signed [ACC_BITS-1:0]          acc_in;
   logic signed [ACC_BITS-1:0]          biased;
   logic signed [ACC_BITS-1:0]          rounded;

   // top digit of each operand times its coefficient; leading digit carries the sign
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < NUM_TERMS; k++) begin
         dig[k]  = {first_ff & opr_ff[k][OPW-1],
                    opr_ff[k][OPW-1 -: bqc_pkg::DIGIT_BITS]};
         prod[k] = coef_ff[k] * dig[k];
         sum_in  = sum_in + SUM_BITS'(prod[k]);
      end
      acc_in = (acc_ff <<< bqc_pkg::DIGIT_BITS) + ACC_BITS'(sum_in);
   end

   // operand shift registers and accumulator
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         opr_ff[0]  <= OPW'(x);
         opr_ff[1]  <= OPW'(row.x1);
         opr_ff[2]  <= OPW'(row.x2);
         opr_ff[3]  <= OPW'(row.y1);
         opr_ff[4]  <= OPW'(row.y2);
         coef_ff[0] <= MCOEF'(coefs.b0);
         coef_ff[1] <= MCOEF'(coefs.b1);
         coef_ff[2] <= MCOEF'(coefs.b2);
         coef_ff[3] <= -MCOEF'(coefs.a1);
         coef_ff[4] <= -MCOEF'(coefs.a2);
         acc_ff     <= '0;
         first_ff   <= 1'b1;
      end else if (ctrl.shift) begin
         for (int k = 0; k < NUM_TERMS; k++) begin
            opr_ff[k] <= opr_ff[k] <<< bqc_pkg::DIGIT_BITS;
         end
         acc_ff   <= acc_in;
         first_ff <= 1'b0;
      end
   end

   // round half up, then clamp to the sample range
   always_comb begin
      biased  = acc_ff + HALF;
      rounded = biased >>> bqc_pkg::COEF_FRAC_BITS;
      if (rounded > SAT_HI) begin
         y = SAT_HI[bqc_pkg::SAMPLE_BITS-1:0];
      end else if (rounded < SAT_LO) begin
         y = SAT_LO[bqc_pkg::SAMPLE_BITS-1:0];
      end else begin
         y = rounded[bqc_pkg::SAMPLE_BITS-1:0];
      end
   end

endmodule

// ----- rtl/core/three_biquad_tone_cascade.sv -----
// top level of the three-biquad tone cascade (low shelf, high shelf, presence bell)
// depends on bqc_pkg, bqc_if, bqc_csr, bqc_hist_mem and bqc_mac
//
//   port      kind         direction  content
//   req_bus   stream       in         channel, sample_in
//   rsp_bus   stream       out        channel_out, sample_out
//   csr_*     write port   in         register index and data
//
// a sample is filtered section by section: per section one history read, one operand load,
// the 4-bit digit-serial MAC and one write-back; the finish state then loads the output
// register, and the next transfer is taken only once the sequencer is back in idle
// a bypassed sample goes straight to the finish state, which loads the output register
// synchronous active-high reset clears the history valid bits and the registers
// a finished response waits in the output register while the next sample is taken; a sample
// that finishes while that register still holds an untaken response waits until it is taken
module three_biquad_tone_cascade (
   input  logic                               clock,
   input  logic                               reset,
   bqc_req_if.sink                            req_bus,
   bqc_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [bqc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bqc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_MAC,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type                       state_ff;
   logic [bqc_pkg::CHAN_BITS-1:0]   chan_ff;
   bqc_pkg::sample_type             x_ff;
   logic [bqc_pkg::SEC_BITS-1:0]    sec_ff;
   logic [bqc_pkg::CNT_BITS-1:0]    cnt_ff;
   logic                            rsp_valid_ff;
   logic [bqc_pkg::CHAN_BITS-1:0]   rsp_chan_ff;
   bqc_pkg::sample_type             rsp_sample_ff;

   logic                            active;
   logic                            filter_in;
   logic                            req_xfer;
   logic [bqc_pkg::ROW_BITS-1:0]    row_addr;
   bqc_pkg::coef_set_type           coefs;
   bqc_pkg::hist_req_type           hist_req;
   bqc_pkg::hist_row_type           hist_row;
   bqc_pkg::mac_ctrl_type           mac_ctrl;
   bqc_pkg::sample_type             sec_y;

   bqc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sec       (sec_ff),
      .active    (active),
      .coefs     (coefs)
   );

   bqc_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .req     (hist_req),
      .rd_data (hist_row)
   );

   bqc_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .x     (x_ff),
      .row   (hist_row),
      .coefs (coefs),
      .y     (sec_y)
   );

   // input transfer and filter decision
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign filter_in     = active &&
      ({1'b0, req_bus.channel} < (bqc_pkg::CHAN_BITS + 1)'(bqc_pkg::NUM_CHANNELS));

   // history row of the current channel and section
   assign row_addr = bqc_pkg::ROW_BITS'(
      bqc_pkg::ROW_BITS'(chan_ff) * bqc_pkg::ROW_BITS'(bqc_pkg::NUM_SECTIONS)
      + bqc_pkg::ROW_BITS'(sec_ff));

   // memory and MAC strobes
   always_comb begin
      hist_req.rd_en      = (state_ff == ST_READ);
      hist_req.rd_addr    = row_addr;
      hist_req.wr_en      = (state_ff == ST_WRITE);
      hist_req.wr_addr    = row_addr;
      hist_req.wr_data.x1 = x_ff;
      hist_req.wr_data.x2 = hist_row.x1;
      hist_req.wr_data.y1 = sec_y;
      hist_req.wr_data.y2 = hist_row.y1;
      mac_ctrl.load       = (state_ff == ST_LOAD);
      mac_ctrl.shift      = (state_ff == ST_MAC);
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: load a finished sample, else drop a taken response
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff  <= 1'b1;
            rsp_chan_ff   <= chan_ff;
            rsp_sample_ff <= x_ff;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  chan_ff  <= req_bus.channel;
                  x_ff     <= req_bus.sample_in;
                  sec_ff   <= '0;
                  state_ff <= filter_in ? ST_READ : ST_FINISH;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == bqc_pkg::CNT_BITS'(bqc_pkg::NUM_DIGITS - 1)) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               x_ff <= sec_y;
               if (sec_ff == bqc_pkg::SEC_BITS'(bqc_pkg::NUM_SECTIONS - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  sec_ff   <= sec_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.channel_out = rsp_chan_ff;
   assign rsp_bus.sample_out  = rsp_sample_ff;

endmodule

// ----- bench/tb_three_biquad_tone_cascade.sv -----
// self-checking bench for the three-biquad tone cascade: directed corner cases, then random phases
// depends on bqc_pkg, bqc_if and the three_biquad_tone_cascade top level
`timescale 1ns / 1ps

module tb_three_biquad_tone_cascade;
   import bqc_pkg::*;

   localparam int RUN_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_LIMIT = 100;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_SAMPLES = 125;

   // index past the last register, writes to it must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_type   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam coef_type   COEF_ONE   = coef_type'(1 << COEF_FRAC_BITS);

   typedef struct {
      logic [CHAN_BITS-1:0] channel;
      sample_type           sample;
   } tone_sample_type;

   typedef enum {SET_GENTLE, SET_RANDOM, SET_EXTREME, SET_UNITY} coef_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   bqc_req_if req_bus ();
   bqc_rsp_if rsp_bus ();

   three_biquad_tone_cascade u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // equalizer copy: registers and per channel, per section history
   logic                eq_active;
   logic [NUM_BITS-1:0] num_reg [NUM_SECTIONS];
   logic [DEN_BITS-1:0] den_reg [NUM_SECTIONS];
   sample_type          hist_x1 [NUM_CHANNELS][NUM_SECTIONS];
   sample_type          hist_x2 [NUM_CHANNELS][NUM_SECTIONS];
   sample_type          hist_y1 [NUM_CHANNELS][NUM_SECTIONS];
   sample_type          hist_y2 [NUM_CHANNELS][NUM_SECTIONS];

   tone_sample_type pending_samples [$];
   tone_sample_type awaited_results [$];

   bit          req_calm;
   bit          rsp_calm;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned stall_draw;
   int unsigned mismatches;
   int unsigned cycle_count;
   tone_sample_type next_sample;
   tone_sample_type want;

   // filtered value of one sample through the three sections, history advanced
   function automatic tone_sample_type cascade_out(input logic [CHAN_BITS-1:0] ch,
                                                   input sample_type x);
      tone_sample_type res;
      sample_type   v;
      coef_type     b0, b1, b2, a1, a2;
      longint       acc;
      longint       r;
      v = x;
      if (eq_active && ch < NUM_CHANNELS) begin
         for (int s = 0; s < NUM_SECTIONS; s++) begin
            b0 = coef_type'(num_reg[s][0 +: COEF_BITS]);
            b1 = coef_type'(num_reg[s][COEF_BITS +: COEF_BITS]);
            b2 = coef_type'(num_reg[s][2*COEF_BITS +: COEF_BITS]);
            a1 = coef_type'(den_reg[s][0 +: COEF_BITS]);
            a2 = coef_type'(den_reg[s][COEF_BITS +: COEF_BITS]);
            acc = longint'(b0) * longint'(v)
                + longint'(b1) * longint'(hist_x1[ch][s])
                + longint'(b2) * longint'(hist_x2[ch][s])
                - longint'(a1) * longint'(hist_y1[ch][s])
                - longint'(a2) * longint'(hist_y2[ch][s]);
            // round half up, floor shift, then clamp to the sample range
            r = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (r > longint'(SAMPLE_MAX))
               r = longint'(SAMPLE_MAX);
            else if (r < longint'(SAMPLE_MIN))
               r = longint'(SAMPLE_MIN);
            hist_x2[ch][s] = hist_x1[ch][s];
            hist_x1[ch][s] = v;
            hist_y2[ch][s] = hist_y1[ch][s];
            hist_y1[ch][s] = sample_type'(r);
            v = sample_type'(r);
         end
      end
      res.channel = ch;
      res.sample  = v;
      return res;
   endfunction

   function automatic int unsigned draw_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [NUM_BITS-1:0] pack_num(input coef_type b0, b1, b2);
      return {b2, b1, b0};
   endfunction

   function automatic logic [DEN_BITS-1:0] pack_den(input coef_type a1, a2);
      return {a2, a1};
   endfunction

   function automatic coef_type extreme_coef(input int phase);
      if (phase == 0)
         return COEF_MAX;
      if (phase == 1)
         return COEF_MIN;
      return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // register write, then the equalizer copy follows once the write edge has passed
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_ACTIVE:         eq_active  = data[0];
         REG_LOW_SHELF_NUM:  num_reg[0] = data[NUM_BITS-1:0];
         REG_LOW_SHELF_DEN:  den_reg[0] = data[DEN_BITS-1:0];
         REG_HIGH_SHELF_NUM: num_reg[1] = data[NUM_BITS-1:0];
         REG_HIGH_SHELF_DEN: den_reg[1] = data[DEN_BITS-1:0];
         REG_BELL_NUM:       num_reg[2] = data[NUM_BITS-1:0];
         REG_BELL_DEN:       den_reg[2] = data[DEN_BITS-1:0];
         default: ;
      endcase
   endtask

   // both coefficient registers of one section; junk above the denominator fields
   task automatic write_section(input int s, input logic [NUM_BITS-1:0] num,
                                input logic [DEN_BITS-1:0] den);
      logic [CSR_DATA_BITS-1:0] wide;
      wide = CSR_DATA_BITS'({$urandom, $urandom});
      wide[DEN_BITS-1:0] = den;
      write_reg(CSR_INDEX_BITS'(REG_LOW_SHELF_NUM + 2 * s), num);
      write_reg(CSR_INDEX_BITS'(REG_LOW_SHELF_DEN + 2 * s), wide);
   endtask

   task automatic add_sample(input logic [CHAN_BITS-1:0] ch, input sample_type smp);
      pending_samples.push_back('{ch, smp});
   endtask

   // idle means nothing queued, nothing offered and nothing outstanding
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || awaited_results.size() != 0);
   endtask

   // request driver: one transfer per queued sample, random gap after each unless calm
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            awaited_results.push_back(cascade_out(req_bus.channel, req_bus.sample_in));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= req_gap - 1;
            end else if (pending_samples.size() != 0) begin
               next_sample = pending_samples.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.channel   <= next_sample.channel;
               req_bus.sample_in <= next_sample.sample;
               req_gap           <= draw_wait(req_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare each transfer with the oldest expectation, random stalls unless calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected response ch %0d sample %0d",
                                         rsp_bus.channel_out, rsp_bus.sample_out));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_bus.channel_out !== want.channel)
                  report_mismatch($sformatf("channel_out %0d, want %0d",
                                            rsp_bus.channel_out, want.channel));
               if (rsp_bus.sample_out !== want.sample)
                  report_mismatch($sformatf("sample_out %0d, want %0d (ch %0d)",
                                            rsp_bus.sample_out, want.sample, want.channel));
            end
            stall_draw = draw_wait(rsp_calm);
            if (stall_draw == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               rsp_stall     <= stall_draw;
            end
         end else if (rsp_stall != 0) begin
            rsp_stall     <= rsp_stall - 1;
            rsp_bus.ready <= (rsp_stall == 1);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_BITS-1:0] junk;
      coef_type    c [5];
      coef_style_type style;
      int          kind;
      sample_type  smp;

      req_bus.valid     = 1'b0;
      req_bus.channel   = '0;
      req_bus.sample_in = '0;
      rsp_bus.ready     = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      mismatches        = 0;
      cycle_count       = 0;
      req_calm          = 1'b0;
      rsp_calm          = 1'b0;

      // equalizer copy at reset: bypass, unity numerators, zero denominators
      eq_active = 1'b0;
      for (int s = 0; s < NUM_SECTIONS; s++) begin
         num_reg[s] = NUM_RESET;
         den_reg[s] = '0;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            hist_x1[ch][s] = '0;
            hist_x2[ch][s] = '0;
            hist_y1[ch][s] = '0;
            hist_y2[ch][s] = '0;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // bypass straight out of reset
      add_sample(1'b0, SAMPLE_MAX);
      add_sample(1'b1, SAMPLE_MIN);
      add_sample(1'b0, '0);
      add_sample(1'b1, sample_type'(-1));
      wait_idle();

      // filtering with reset coefficients is unity gain
      write_reg(REG_ACTIVE, CSR_DATA_BITS'(1));
      add_sample(1'b0, SAMPLE_MAX);
      add_sample(1'b1, SAMPLE_MIN);
      add_sample(1'b0, sample_type'(1));
      add_sample(1'b1, sample_type'(-1));
      wait_idle();

      // gain near +8 in the low shelf saturates both ways
      write_section(0, pack_num(COEF_MAX, '0, '0), pack_den('0, '0));
      add_sample(1'b0, SAMPLE_MAX);
      add_sample(1'b1, SAMPLE_MIN);
      add_sample(1'b0, sample_type'(1000000));
      wait_idle();

      // feedback and feedforward taps at their extremes
      write_section(1, pack_num(COEF_MIN, COEF_MAX, COEF_MIN), pack_den(COEF_MIN, COEF_MAX));
      write_section(2, pack_num(COEF_MAX, COEF_MIN, COEF_MAX), pack_den(COEF_MAX, COEF_MIN));
      add_sample(1'b0, SAMPLE_MIN);
      add_sample(1'b0, SAMPLE_MAX);
      add_sample(1'b1, sample_type'(777));
      add_sample(1'b1, sample_type'(-4096));
      wait_idle();

      // write past the last register is dropped; bypass keeps history frozen
      write_reg(REG_UNUSED, '1);
      write_reg(REG_ACTIVE, {{(CSR_DATA_BITS-1){1'b1}}, 1'b0});
      add_sample(1'b0, SAMPLE_MAX);
      add_sample(1'b1, sample_type'(123));
      wait_idle();
      write_reg(REG_ACTIVE, CSR_DATA_BITS'(1));
      add_sample(1'b0, sample_type'(-1000));
      add_sample(1'b1, sample_type'(5555));
      add_sample(1'b0, SAMPLE_MIN);
      wait_idle();

      // random phases: new coefficients per section, then a block of samples
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         for (int s = 0; s < NUM_SECTIONS; s++) begin
            style = (p < 2) ? SET_EXTREME : coef_style_type'($urandom_range(0, 3));
            case (style)
               SET_GENTLE: begin
                  c[0] = coef_type'(int'(COEF_ONE) + int'($urandom_range(0, 8192)) - 4096);
                  c[1] = coef_type'(int'($urandom_range(0, 8192)) - 4096);
                  c[2] = coef_type'(int'($urandom_range(0, 8192)) - 4096);
                  c[3] = coef_type'(int'($urandom_range(0, 16000)) - 8000);
                  c[4] = coef_type'(int'($urandom_range(0, 16000)) - 8000);
               end
               SET_RANDOM: begin
                  foreach (c[k])
                     c[k] = coef_type'($urandom);
               end
               SET_EXTREME: begin
                  foreach (c[k])
                     c[k] = extreme_coef(p);
               end
               default: begin
                  c[0] = COEF_ONE;
                  for (int k = 1; k < 5; k++)
                     c[k] = '0;
               end
            endcase
            write_section(s, pack_num(c[0], c[1], c[2]), pack_den(c[3], c[4]));
         end
         junk = CSR_DATA_BITS'({$urandom, $urandom});
         write_reg(REG_ACTIVE, {junk[CSR_DATA_BITS-1:1], (p < 2) || ($urandom_range(0, 5) != 0)});

         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
               smp = sample_type'($urandom);
            else if (kind < 8)
               smp = sample_type'(int'($urandom_range(0, 512)) - 256);
            else
               case ($urandom_range(0, 3))
                  0:       smp = SAMPLE_MAX;
                  1:       smp = SAMPLE_MIN;
                  2:       smp = '0;
                  default: smp = sample_type'(-1);
               endcase
            add_sample(CHAN_BITS'($urandom_range(0, NUM_CHANNELS - 1)), smp);
         end
         wait_idle();
      end

      // drain, then wait out the drain period for stray responses
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/bqc_pkg.sv
rtl/core/bqc_if.sv
rtl/core/bqc_csr.sv
rtl/core/bqc_hist_mem.sv
rtl/core/bqc_mac.sv
rtl/core/three_biquad_tone_cascade.sv
bench/tb_three_biquad_tone_cascade.sv
